// ===== design/bptc_pkg.sv =====
`default_nettype none

package bptc_pkg;

	// Widths of the port fields.
	localparam int CAL_W      = 16;
	localparam int RAW_W      = 24;
	localparam int PRESS_W    = 32;
	localparam int TEMP_W     = 19;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	// Widths of the internal terms.
	localparam int DT_W   = 25;
	localparam int PROD_W = 42;
	localparam int SQ_W   = 48;
	localparam int T2_W   = 18;
	localparam int CORR_W = 36;
	localparam int WIDE_W = 40;
	localparam int LO_W   = 20;

	// Temperature thresholds in 0.01 C.
	localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;

	// Gains of the second-order correction terms.
	localparam int OFF2_WARM_GAIN  = 5;
	localparam int OFF2_COLD_GAIN  = 7;
	localparam int SENS2_COLD_GAIN = 11;

	// Calibration reset values.
	localparam logic [CAL_W-1:0] PRESS_SENS_RST = 16'd40127;
	localparam logic [CAL_W-1:0] PRESS_OFF_RST  = 16'd36924;
	localparam logic [CAL_W-1:0] SENS_TC_RST    = 16'd23317;
	localparam logic [CAL_W-1:0] OFF_TC_RST     = 16'd23282;
	localparam logic [CAL_W-1:0] REF_TEMP_RST   = 16'd33464;
	localparam logic [CAL_W-1:0] TEMP_SLOPE_RST = 16'd28312;

	// Register index, taken from the word address.
	typedef enum logic [2:0] {
		REG_PRESS_SENS,
		REG_PRESS_OFF,
		REG_SENS_TC,
		REG_OFF_TC,
		REG_REF_TEMP,
		REG_TEMP_SLOPE
	} cal_reg_t;

endpackage

`default_nettype wire

// ===== design/baro_pressure_temp_compensation.sv =====
`default_nettype none

// Compensated pressure (0.01 mbar) and temperature (0.01 C) from one raw pressure
// and one raw temperature word, using six 16-bit calibration words on the APB port.
// The datapath is a nine-stage pipeline: a word may be started in every cycle, busy
// never rises, and each result appears on done once its word has passed stages s1 to s9.
// The depth is set by the chain of products (first-order terms, the squared second-order
// terms, and the final 24 x 40 pressure product split into two partial products).
// The receiver cannot stall the block; every result is shown for one cycle only.
// Calibration writes should be made while no word is in flight.
module baro_pressure_temp_compensation (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [bptc_pkg::RAW_W-1:0]         raw_pressure,
	input  wire logic [bptc_pkg::RAW_W-1:0]         raw_temperature,
	output logic                                    done,
	output logic signed [bptc_pkg::PRESS_W-1:0]     pressure,
	output logic signed [bptc_pkg::TEMP_W-1:0]      temperature,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [bptc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [bptc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bptc_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                    pready
);
	import bptc_pkg::*;

	// Calibration registers.
	logic [CAL_W-1:0] press_sens_q;
	logic [CAL_W-1:0] press_off_q;
	logic [CAL_W-1:0] sens_tc_q;
	logic [CAL_W-1:0] off_tc_q;
	logic [CAL_W-1:0] ref_temp_q;
	logic [CAL_W-1:0] temp_slope_q;

	cal_reg_t reg_sel;
	logic     cfg_wr;

	// Valid bits of the pipeline.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;

	// Stage 1: temperature difference.
	logic signed [DT_W-1:0]   dt_s1;
	logic [RAW_W-1:0]         d1_s1;
	// Stage 2: first-order products.
	logic signed [PROD_W-1:0] ts_prod_s2, off_prod_s2, sens_prod_s2;
	logic [SQ_W-1:0]          dt_sq_s2;
	logic [RAW_W-1:0]         d1_s2;
	// Stage 3: first-order TEMP, OFF, SENS and T2.
	logic signed [TEMP_W-1:0] temp1_s3;
	logic signed [WIDE_W-1:0] off1_s3, sens1_s3;
	logic [T2_W-1:0]          t2_s3;
	logic [RAW_W-1:0]         d1_s3;
	// Stage 4: squared distances to the thresholds.
	logic [CORR_W-1:0]        warm_sq_s4, cold_sq_s4;
	logic                     warm_s4, cold_s4;
	logic signed [TEMP_W-1:0] temp1_s4;
	logic signed [WIDE_W-1:0] off1_s4, sens1_s4;
	logic [T2_W-1:0]          t2_s4;
	logic [RAW_W-1:0]         d1_s4;
	// Stage 5: second-order corrections.
	logic [WIDE_W-1:0]        off2_s5, sens2_s5;
	logic [T2_W-1:0]          t2_s5;
	logic                     warm_s5;
	logic signed [TEMP_W-1:0] temp1_s5;
	logic signed [WIDE_W-1:0] off1_s5, sens1_s5;
	logic [RAW_W-1:0]         d1_s5;
	// Stage 6: corrected TEMP, OFF and SENS.
	logic signed [TEMP_W-1:0] temp_s6;
	logic signed [WIDE_W-1:0] off_s6, sens_s6;
	logic [RAW_W-1:0]         d1_s6;
	// Stage 7: partial products of the pressure.
	logic [RAW_W+LO_W-1:0]              p_lo_s7;
	logic signed [RAW_W+WIDE_W-LO_W:0]  p_hi_s7;
	logic signed [TEMP_W-1:0]           temp_s7;
	logic signed [WIDE_W-1:0]           off_s7;
	// Stage 8: full pressure product.
	logic signed [63:0]       p_full_s8;
	logic signed [TEMP_W-1:0] temp_s8;
	logic signed [WIDE_W-1:0] off_s8;
	// Stage 9: outputs.
	logic signed [PRESS_W-1:0] pressure_s9;
	logic signed [TEMP_W-1:0]  temp_s9;

	// Combinational terms between stages.
	logic signed [DT_W-1:0]   dt_c;
	logic signed [PROD_W-1:0] dt_x;
	logic signed [SQ_W-1:0]   dt_sq_x;
	logic signed [TEMP_W-1:0] warm_c, cold_c;
	logic signed [37:0]       warm_x, cold_x;
	logic signed [37:0]       warm_sq_c, cold_sq_c;
	logic [WIDE_W-1:0]        warm5_c;
	logic [WIDE_W-1:0]        cold7_c, cold11_c;
	logic signed [43:0]       p_diff_c;

	// The block takes a word in every cycle.
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Configuration decode.
	assign reg_sel = cal_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_sens_q <= PRESS_SENS_RST;
			press_off_q  <= PRESS_OFF_RST;
			sens_tc_q    <= SENS_TC_RST;
			off_tc_q     <= OFF_TC_RST;
			ref_temp_q   <= REF_TEMP_RST;
			temp_slope_q <= TEMP_SLOPE_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_PRESS_SENS: press_sens_q <= pwdata[CAL_W-1:0];
				REG_PRESS_OFF:  press_off_q  <= pwdata[CAL_W-1:0];
				REG_SENS_TC:    sens_tc_q    <= pwdata[CAL_W-1:0];
				REG_OFF_TC:     off_tc_q     <= pwdata[CAL_W-1:0];
				REG_REF_TEMP:   ref_temp_q   <= pwdata[CAL_W-1:0];
				REG_TEMP_SLOPE: temp_slope_q <= pwdata[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back; unused addresses read as zero.
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_PRESS_SENS: prdata = APB_DATA_W'(press_sens_q);
			REG_PRESS_OFF:  prdata = APB_DATA_W'(press_off_q);
			REG_SENS_TC:    prdata = APB_DATA_W'(sens_tc_q);
			REG_OFF_TC:     prdata = APB_DATA_W'(off_tc_q);
			REG_REF_TEMP:   prdata = APB_DATA_W'(ref_temp_q);
			REG_TEMP_SLOPE: prdata = APB_DATA_W'(temp_slope_q);
			default:        prdata = '0;
		endcase
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// Combinational terms feeding the stages.
	always_comb begin
		dt_c      = $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temp_q, 8'd0});
		dt_x      = PROD_W'(dt_s1);
		dt_sq_x   = SQ_W'(dt_s1);
		warm_c    = temp1_s3 - TEMP_REF;
		cold_c    = temp1_s3 - TEMP_COLD;
		warm_x    = 38'(warm_c);
		cold_x    = 38'(cold_c);
		warm_sq_c = warm_x * warm_x;
		cold_sq_c = cold_x * cold_x;
		warm5_c   = WIDE_W'(warm_sq_s4) * WIDE_W'(OFF2_WARM_GAIN);
		cold7_c   = WIDE_W'(cold_sq_s4) * WIDE_W'(OFF2_COLD_GAIN);
		cold11_c  = WIDE_W'(cold_sq_s4) * WIDE_W'(SENS2_COLD_GAIN);
		p_diff_c  = 44'($signed(p_full_s8[63:21])) - 44'(off_s8);
	end

	// Datapath registers; payload needs no reset.
	always_ff @(posedge clk) begin
		// Stage 1: difference to the reference temperature.
		dt_s1 <= dt_c;
		d1_s1 <= raw_pressure;

		// Stage 2: products with the temperature difference.
		ts_prod_s2   <= dt_x * $signed(PROD_W'({1'b0, temp_slope_q}));
		off_prod_s2  <= dt_x * $signed(PROD_W'({1'b0, off_tc_q}));
		sens_prod_s2 <= dt_x * $signed(PROD_W'({1'b0, sens_tc_q}));
		dt_sq_s2     <= SQ_W'(dt_sq_x * dt_sq_x);
		d1_s2        <= d1_s1;

		// Stage 3: first-order results; taking the upper bits floors the quotient.
		temp1_s3 <= $signed(ts_prod_s2[41:23]) + TEMP_REF;
		off1_s3  <= WIDE_W'($signed(off_prod_s2[41:7]))
			+ $signed({8'd0, press_off_q, 16'd0});
		sens1_s3 <= WIDE_W'($signed(sens_prod_s2[41:8]))
			+ $signed({9'd0, press_sens_q, 15'd0});
		t2_s3    <= T2_W'(dt_sq_s2[SQ_W-1:31]);
		d1_s3    <= d1_s2;

		// Stage 4: threshold tests and squared distances.
		warm_sq_s4 <= warm_sq_c[CORR_W-1:0];
		cold_sq_s4 <= cold_sq_c[CORR_W-1:0];
		warm_s4    <= temp1_s3 < TEMP_REF;
		cold_s4    <= temp1_s3 < TEMP_COLD;
		temp1_s4   <= temp1_s3;
		off1_s4    <= off1_s3;
		sens1_s4   <= sens1_s3;
		t2_s4      <= t2_s3;
		d1_s4      <= d1_s3;

		// Stage 5: second-order corrections, zero at or above TEMP_REF.
		if (warm_s4) begin
			off2_s5  <= (warm5_c >> 1) + (cold_s4 ? cold7_c : '0);
			sens2_s5 <= (warm5_c >> 2) + (cold_s4 ? (cold11_c >> 1) : '0);
			t2_s5    <= t2_s4;
		end else begin
			off2_s5  <= '0;
			sens2_s5 <= '0;
			t2_s5    <= '0;
		end
		warm_s5  <= warm_s4;
		temp1_s5 <= temp1_s4;
		off1_s5  <= off1_s4;
		sens1_s5 <= sens1_s4;
		d1_s5    <= d1_s4;

		// Stage 6: apply the corrections.
		temp_s6 <= temp1_s5 - $signed({1'b0, t2_s5});
		off_s6  <= off1_s5 - $signed(off2_s5);
		sens_s6 <= sens1_s5 - $signed(sens2_s5);
		d1_s6   <= d1_s5;

		// Stage 7: raw pressure times SENS, in a low unsigned and a high signed half.
		p_lo_s7 <= (RAW_W+LO_W)'(d1_s6) * (RAW_W+LO_W)'(sens_s6[LO_W-1:0]);
		p_hi_s7 <= (RAW_W+WIDE_W-LO_W+1)'($signed({1'b0, d1_s6}))
			* (RAW_W+WIDE_W-LO_W+1)'($signed(sens_s6[WIDE_W-1:LO_W]));
		temp_s7 <= temp_s6;
		off_s7  <= off_s6;

		// Stage 8: join the partial products.
		p_full_s8 <= (64'(p_hi_s7) <<< LO_W) + $signed({20'd0, p_lo_s7});
		temp_s8   <= temp_s7;
		off_s8    <= off_s7;

		// Stage 9: remove the offset and scale.
		pressure_s9 <= PRESS_W'($signed(p_diff_c[43:15]));
		temp_s9     <= temp_s8;
	end

	assign done        = valid_s9;
	assign pressure    = pressure_s9;
	assign temperature = temp_s9;

	// Every accepted word produces a result on done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##9 done)
		else $error("result missing nine cycles after start");

	// No result without a matching earlier start.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 9))
		else $error("result without a matching start");

	// The cold range lies inside the range that gets corrections.
	a_cold_in_warm: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && cold_s4 |-> warm_s4)
		else $error("cold flag set above the correction threshold");

	// Above the threshold no correction reaches the next stage.
	a_no_corr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !warm_s5 |-> off2_s5 == '0 && sens2_s5 == '0 && t2_s5 == '0)
		else $error("second-order correction applied above threshold");

endmodule

`default_nettype wire
